// ===== rtl/bcdep_pkg.sv =====
// bcdep_pkg: shared types, constants and helper functions for the
// rtc-to-epoch conversion pipeline. no dependencies.

package bcdep_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_STOPPED     = 2'd1,
        ST_IMPLAUSIBLE = 2'd2
    } t_status;

    // raw rtc register set, one request
    typedef struct packed {
        logic [7:0] seconds_reg;
        logic [7:0] minutes_reg;
        logic [7:0] hours_reg;
        logic [7:0] day_reg;
        logic [7:0] month_reg;
        logic [7:0] year_reg;
    } t_rtc_req;

    // converted result
    typedef struct packed {
        t_status     status;
        logic [32:0] epoch_seconds;
    } t_epoch_rsp;

    // decoded fields after the first stage
    typedef struct packed {
        t_status    status;
        logic [6:0] second;
        logic [6:0] minute;
        logic [5:0] hour;
        logic [5:0] day;
        logic [4:0] shifted;  // month counted from march
        logic       early;    // era year fell to 1999 (previous era)
        logic [8:0] yoe;      // year of era
    } t_dec;

    // day-of-era and time of day after the second stage
    typedef struct packed {
        t_status     status;
        logic        early;
        logic [17:0] doe;
        logic [17:0] tod;
    } t_doe;

    // day count since 1970 after the third stage
    typedef struct packed {
        t_status     status;
        logic [16:0] days;
        logic [17:0] tod;
    } t_days;

    localparam logic [6:0]  MIN_YEAR_RESET = 7'd26;
    localparam logic [8:0]  YOE_PREV_ERA   = 9'd399;
    // era * 146097 - 719468 for era 4 (negated) and era 5
    localparam logic [17:0] DAYS_PREV_ERA_SUB = 18'd135080;
    localparam logic [17:0] DAYS_ERA_ADD      = 18'd11017;
    localparam logic [16:0] SEC_PER_DAY       = 17'd86400;

    // bcd decode; nibbles above nine pass through unchanged
    function automatic logic [7:0] bcd_value(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'b0000, v[7:4]};
        return (hi << 3) + (hi << 1) + {4'b0000, v[3:0]};
    endfunction

    // (153 * shifted + 2) / 5 for shifted month 0..22
    function automatic logic [9:0] doy_base(input logic [4:0] shifted);
        logic [9:0] res;
        case (shifted)
            5'd0:    res = 10'd0;
            5'd1:    res = 10'd31;
            5'd2:    res = 10'd61;
            5'd3:    res = 10'd92;
            5'd4:    res = 10'd122;
            5'd5:    res = 10'd153;
            5'd6:    res = 10'd184;
            5'd7:    res = 10'd214;
            5'd8:    res = 10'd245;
            5'd9:    res = 10'd275;
            5'd10:   res = 10'd306;
            5'd11:   res = 10'd337;
            5'd12:   res = 10'd367;
            5'd13:   res = 10'd398;
            5'd14:   res = 10'd428;
            5'd15:   res = 10'd459;
            5'd16:   res = 10'd490;
            5'd17:   res = 10'd520;
            5'd18:   res = 10'd551;
            5'd19:   res = 10'd581;
            5'd20:   res = 10'd612;
            5'd21:   res = 10'd643;
            5'd22:   res = 10'd673;
            default: res = 10'd0;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/bcdep_decode.sv =====
// bcdep_decode: first pipeline stage, masks and bcd-decodes the rtc
// registers, sets the status and the era split. uses bcdep_pkg.

module bcdep_decode import bcdep_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_rtc_req   i_req,
    input  logic [6:0] i_min_year,
    output logic       o_valid,
    input  logic       i_ready,
    output t_dec       o_dec
);

    logic       r_valid;
    t_dec       r_dec;
    t_dec       n_dec;
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] day;

    // decode and classify
    always_comb begin
        year  = bcd_value(i_req.year_reg);
        month = bcd_value({3'b000, i_req.month_reg[4:0]});
        day   = bcd_value({2'b00, i_req.day_reg[5:0]});

        n_dec.second = 7'(bcd_value({1'b0, i_req.seconds_reg[6:0]}));
        n_dec.minute = 7'(bcd_value({1'b0, i_req.minutes_reg[6:0]}));
        n_dec.hour   = 6'(bcd_value({2'b00, i_req.hours_reg[5:0]}));
        n_dec.day    = day[5:0];

        if (i_req.seconds_reg[7]) begin
            n_dec.status = ST_STOPPED;
        end else if (year < {1'b0, i_min_year} || day == 8'd0) begin
            n_dec.status = ST_IMPLAUSIBLE;
        end else begin
            n_dec.status = ST_OK;
        end

        // january, february and month zero belong to the previous year
        if (month > 8'd2) begin
            n_dec.shifted = 5'(month - 8'd3);
            n_dec.early   = 1'b0;
            n_dec.yoe     = {1'b0, year};
        end else begin
            n_dec.shifted = 5'(month + 8'd9);
            n_dec.early   = (year == 8'd0);
            n_dec.yoe     = (year == 8'd0) ? YOE_PREV_ERA : {1'b0, 8'(year - 8'd1)};
        end
    end

    assign o_ready = !r_valid || i_ready;

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

// ===== rtl/bcdep_day_count.sv =====
// bcdep_day_count: second and third pipeline stages, day of era and time
// of day, then days since 1970. uses bcdep_pkg.

module bcdep_day_count import bcdep_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_dec  i_dec,
    output logic  o_valid,
    input  logic  i_ready,
    output t_days o_days
);

    logic        r_valid_doe;
    t_doe        r_doe;
    t_doe        n_doe;
    logic        r_valid_days;
    t_days       r_days;
    t_days       n_days;
    logic        ready_days;
    logic [9:0]  doy;
    logic [1:0]  cent;

    // day of era from year of era and shifted month, plus time of day
    always_comb begin
        doy = doy_base(i_dec.shifted) + {4'b0000, i_dec.day} - 10'd1;
        if (i_dec.yoe >= 9'd300) begin
            cent = 2'd3;
        end else if (i_dec.yoe >= 9'd200) begin
            cent = 2'd2;
        end else if (i_dec.yoe >= 9'd100) begin
            cent = 2'd1;
        end else begin
            cent = 2'd0;
        end
        n_doe.status = i_dec.status;
        n_doe.early  = i_dec.early;
        n_doe.doe    = 18'(i_dec.yoe) * 18'd365 + 18'(i_dec.yoe >> 2)
                     - 18'(cent) + 18'(doy);
        n_doe.tod    = 18'(i_dec.hour) * 18'd3600 + 18'(i_dec.minute) * 18'd60
                     + 18'(i_dec.second);
    end

    // era offset relative to 1970-01-01
    always_comb begin
        n_days.status = r_doe.status;
        n_days.tod    = r_doe.tod;
        if (r_doe.early) begin
            n_days.days = 17'(r_doe.doe - DAYS_PREV_ERA_SUB);
        end else begin
            n_days.days = 17'(r_doe.doe + DAYS_ERA_ADD);
        end
    end

    assign ready_days = !r_valid_days || i_ready;
    assign o_ready    = !r_valid_doe || ready_days;

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_doe  <= 1'b0;
            r_valid_days <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid_doe <= i_valid;
            end
            if (ready_days) begin
                r_valid_days <= r_valid_doe;
            end
        end
        if (o_ready && i_valid) begin
            r_doe <= n_doe;
        end
        if (ready_days && r_valid_doe) begin
            r_days <= n_days;
        end
    end

    assign o_valid = r_valid_days;
    assign o_days  = r_days;

endmodule

// ===== rtl/bcdep_scale.sv =====
// bcdep_scale: last pipeline stage and output register, days times 86400
// plus time of day, zeroed when the status is not ok. uses bcdep_pkg.

module bcdep_scale import bcdep_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_days      i_days,
    output logic       o_valid,
    input  logic       i_ready,
    output t_epoch_rsp o_rsp
);

    logic        r_valid;
    t_epoch_rsp  r_rsp;
    t_epoch_rsp  n_rsp;
    logic [32:0] secs;

    // seconds since epoch
    always_comb begin
        secs = 33'(i_days.days) * 33'(SEC_PER_DAY) + 33'(i_days.tod);
        n_rsp.status        = i_days.status;
        n_rsp.epoch_seconds = (i_days.status == ST_OK) ? secs : 33'd0;
    end

    assign o_ready = !r_valid || i_ready;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== rtl/bcd_rtc_to_epoch_seconds_unit.sv =====
// bcd_rtc_to_epoch_seconds_unit: top level of the rtc register to unix
// epoch converter. uses bcdep_pkg, bcdep_decode, bcdep_day_count, bcdep_scale.
//
// usage:
//   request channel i_valid/o_ready carries one raw rtc register set
//   (i_req). response channel o_valid/i_ready returns status and epoch
//   seconds (o_rsp), one response per request, in request order.
//   config channel i_cfg_valid/o_cfg_ready writes min_year (i_cfg_data);
//   it is always ready and should only be written while the pipe is empty.
//   a request reaches o_valid through four register stages (decode,
//   day of era, day count, scale and output register).
//   throughput: one request per cycle while i_ready is high; the slowest
//   stage holds one 17x17 constant multiply and an add.
//   reset: clears all stage valid bits and sets min_year to 26.
//   stall: when i_ready is low the response is held; each stage keeps
//   accepting until it is full, so bubbles are squeezed out and up to
//   four requests are held before o_ready drops.

module bcd_rtc_to_epoch_seconds_unit import bcdep_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_rtc_req   i_req,
    output logic       o_valid,
    input  logic       i_ready,
    output t_epoch_rsp o_rsp,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data
);

    logic [6:0] r_min_year;
    logic       dec_valid;
    logic       dec_ready;
    t_dec       dec_data;
    logic       days_valid;
    logic       days_ready;
    t_days      days_data;

    // min_year register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= MIN_YEAR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_min_year <= i_cfg_data;
        end
    end

    // pipeline
    bcdep_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .i_min_year (r_min_year),
        .o_valid    (dec_valid),
        .i_ready    (dec_ready),
        .o_dec      (dec_data)
    );

    bcdep_day_count u_day_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_dec   (dec_data),
        .o_valid (days_valid),
        .i_ready (days_ready),
        .o_days  (days_data)
    );

    bcdep_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (days_valid),
        .o_ready (days_ready),
        .i_days  (days_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== tb/bcd_rtc_to_epoch_seconds_unit_tb.sv =====
// bcd_rtc_to_epoch_seconds_unit_tb: self-checking bench for the rtc register to epoch converter,
// with a directed and random request stream, a clocked driver and monitor, and a local predictor.
// depends on bcdep_pkg and bcd_rtc_to_epoch_seconds_unit.

module bcd_rtc_to_epoch_seconds_unit_tb import bcdep_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_rtc_req   i_req;
    logic       o_valid;
    logic       i_ready;
    t_epoch_rsp o_rsp;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [6:0] i_cfg_data;

    // bench state
    t_rtc_req   rtc_req_q[$];
    t_epoch_rsp epoch_expect_q[$];
    logic [6:0] min_year_shadow;
    bit         req_taken;
    bit         quiet;
    bit         rsp_hold_req;
    int         rsp_hold_left;
    int         mismatch_count;

    bcd_rtc_to_epoch_seconds_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // two bcd digits, each nibble taken as is
    function automatic longint unsigned bcd_decode(input logic [7:0] v);
        return longint'(v[7:4]) * 10 + longint'(v[3:0]);
    endfunction

    function automatic logic [7:0] to_bcd(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    // status and epoch seconds for one register set
    function automatic t_epoch_rsp rtc_to_epoch(input t_rtc_req r, input logic [6:0] year_floor);
        t_epoch_rsp      res;
        longint unsigned sec, mnt, hr, dy, mon, yr;
        longint unsigned era_yr, era, yoe, shf, doy, doe, days, total;
        res.status = ST_OK;
        res.epoch_seconds = '0;
        if (r.seconds_reg[7]) begin
            res.status = ST_STOPPED;
        end else begin
            sec = bcd_decode({1'b0, r.seconds_reg[6:0]});
            mnt = bcd_decode({1'b0, r.minutes_reg[6:0]});
            hr  = bcd_decode({2'b00, r.hours_reg[5:0]});
            dy  = bcd_decode({2'b00, r.day_reg[5:0]});
            mon = bcd_decode({3'b000, r.month_reg[4:0]});
            yr  = bcd_decode(r.year_reg);
            if (yr < longint'(year_floor) || dy == 0) begin
                res.status = ST_IMPLAUSIBLE;
            end else begin
                // january, february and month zero belong to the previous march-based year
                era_yr = (mon <= 2) ? yr + 2000 - 1 : yr + 2000;
                era    = era_yr / 400;
                yoe    = era_yr - era * 400;
                shf    = (mon > 2) ? mon - 3 : mon + 9;
                doy    = (153 * shf + 2) / 5 + dy - 1;
                doe    = yoe * 365 + yoe / 4 - yoe / 100 + doy;
                days   = era * 146097 + doe - 719468;
                total  = days * 86400 + hr * 3600 + mnt * 60 + sec;
                res.epoch_seconds = total[32:0];
            end
        end
        return res;
    endfunction

    // random register set: mostly clean calendar dates, some broken, some raw noise
    function automatic t_rtc_req random_rtc_regs(input logic [6:0] year_floor);
        t_rtc_req    r;
        int unsigned pick;
        int unsigned lo_year;
        pick = $urandom_range(99);
        lo_year = (year_floor > 99) ? 99 : year_floor;
        r.seconds_reg = to_bcd($urandom_range(59));
        r.minutes_reg = to_bcd($urandom_range(59));
        r.hours_reg   = to_bcd($urandom_range(23));
        r.day_reg     = to_bcd($urandom_range(31, 1));
        r.month_reg   = to_bcd($urandom_range(12, 1));
        r.year_reg    = to_bcd($urandom_range(99, lo_year));
        if (pick < 12) begin
            r = {$urandom, 16'($urandom)};
        end else if (pick < 32) begin
            case ($urandom_range(5))
                0: r.seconds_reg[7] = 1'b1;
                1: r.day_reg = {2'($urandom), 6'h00};
                2: begin
                    if (year_floor != 0)
                        r.year_reg = to_bcd($urandom_range(year_floor - 1));
                    else
                        r.seconds_reg[7] = 1'b1;
                end
                3: begin
                    r.seconds_reg[3:0] = 4'($urandom_range(15, 10));
                    r.hours_reg[3:0]   = 4'($urandom_range(15, 10));
                    r.year_reg[7:4]    = 4'($urandom_range(15, 10));
                end
                4: begin
                    r.month_reg = ($urandom_range(1)) ? 8'h00 : to_bcd($urandom_range(19, 13));
                    r.hours_reg = to_bcd($urandom_range(39, 24));
                end
                default: begin
                    // junk in the bits that the masks drop
                    r.minutes_reg[7]   = 1'b1;
                    r.hours_reg[7:6]   = 2'($urandom_range(3, 1));
                    r.day_reg[7:6]     = 2'($urandom_range(3, 1));
                    r.month_reg[7:5]   = 3'($urandom_range(7, 1));
                end
            endcase
        end
        return r;
    endfunction

    task automatic queue_rtc(input logic [7:0] s, input logic [7:0] m, input logic [7:0] h,
                             input logic [7:0] d, input logic [7:0] mo, input logic [7:0] y);
        rtc_req_q.push_back(t_rtc_req'{s, m, h, d, mo, y});
    endtask

    task automatic queue_random(input int n);
        repeat (n) rtc_req_q.push_back(random_rtc_regs(min_year_shadow));
    endtask

    // wait until every request is sent and every response is back
    task automatic wait_drain();
        do begin
            @(negedge i_clk);
            #1;
        end while (rtc_req_q.size() != 0 || i_valid || epoch_expect_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_min_year(input logic [6:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        min_year_shadow = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_valid || req_taken) begin
            req_taken = 1'b0;
            if (rtc_req_q.size() != 0 && (quiet || $urandom_range(99) >= 25)) begin
                i_req   <= rtc_req_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // response ready, with random stalls and an occasional long hold
    always @(negedge i_clk) begin
        if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            i_ready <= 1'b0;
        end else if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_hold_left = 60;
            i_ready <= 1'b0;
        end else begin
            i_ready <= quiet || ($urandom_range(99) >= 25);
        end
    end

    // monitor: check responses, predict accepted requests
    always @(posedge i_clk) begin
        t_epoch_rsp exp_rsp;
        if (i_rst_n && o_valid && i_ready) begin
            if (epoch_expect_q.size() == 0) begin
                $display("%0t: response with none pending, status %0d epoch %0d",
                         $time, o_rsp.status, o_rsp.epoch_seconds);
                mismatch_count++;
            end else begin
                exp_rsp = epoch_expect_q.pop_front();
                if (o_rsp.status !== exp_rsp.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_rsp.status, o_rsp.status);
                    mismatch_count++;
                end
                if (o_rsp.epoch_seconds !== exp_rsp.epoch_seconds) begin
                    $display("%0t: epoch_seconds expected %0d actual %0d",
                             $time, exp_rsp.epoch_seconds, o_rsp.epoch_seconds);
                    mismatch_count++;
                end
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            epoch_expect_q.push_back(rtc_to_epoch(i_req, min_year_shadow));
            req_taken = 1'b1;
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("bcd_rtc_to_epoch_seconds_unit: mismatch");
        $finish;
    end

    // stimulus sequence
    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_req           = '0;
        i_ready         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        min_year_shadow = MIN_YEAR_RESET;
        req_taken       = 1'b0;
        quiet           = 1'b0;
        rsp_hold_req    = 1'b0;
        rsp_hold_left   = 0;
        mismatch_count  = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed cases at the reset floor
        queue_rtc(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h26);  // first day of the floor year
        queue_rtc(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);  // oscillator stopped, all zero
        queue_rtc(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);  // oscillator stopped, all ones
        queue_rtc(8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);  // largest decoded values
        queue_rtc(8'h30, 8'h30, 8'h12, 8'h15, 8'h06, 8'h25);  // year just below floor
        queue_rtc(8'h10, 8'h10, 8'h10, 8'hC0, 8'h05, 8'h30);  // day zero with masked bits set
        queue_rtc(8'h1A, 8'h5F, 8'h2F, 8'h1A, 8'h0F, 8'h9A);  // non-decimal nibbles
        queue_rtc(8'h00, 8'h00, 8'h00, 8'h15, 8'h00, 8'h50);  // month zero
        queue_rtc(8'h59, 8'h59, 8'h23, 8'h29, 8'h02, 8'h28);  // leap day
        queue_rtc(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h99);  // march starts the year
        queue_rtc(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99);  // last second of 2099
        queue_rtc(8'h05, 8'h05, 8'h05, 8'h05, 8'h19, 8'h40);  // month past december
        queue_rtc(8'h00, 8'h00, 8'h00, 8'h28, 8'h02, 8'h26);  // floor year, february
        queue_rtc(8'h45, 8'hD9, 8'hE3, 8'hDF, 8'hF2, 8'h77);  // high bits dropped by masks
        queue_rtc(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00);  // year zero, below floor
        wait_drain();

        // floor at zero: year 2000 and the previous era
        write_min_year(7'd0);
        queue_rtc(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00);
        queue_rtc(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00);
        queue_rtc(8'h59, 8'h59, 8'h23, 8'h29, 8'h02, 8'h00);
        queue_rtc(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00);
        queue_rtc(8'h7F, 8'h7F, 8'h3F, 8'h3F, 8'h1F, 8'h00);
        queue_random(300);
        wait_drain();

        // highest two-digit floor
        write_min_year(7'd99);
        queue_random(250);
        wait_drain();

        // no idling on either side
        write_min_year(7'd60);
        quiet = 1'b1;
        queue_random(300);
        wait_drain();
        quiet = 1'b0;

        repeat (3) begin
            write_min_year(7'($urandom_range(99)));
            queue_random(200);
            wait_drain();
        end

        // back to the reset value: long response hold, then a full pause mid-stream
        write_min_year(MIN_YEAR_RESET);
        rsp_hold_req = 1'b1;
        queue_random(100);
        wait_drain();
        queue_random(100);
        wait_drain();

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("bcd_rtc_to_epoch_seconds_unit: match");
        else
            $display("bcd_rtc_to_epoch_seconds_unit: mismatch");
        $finish;
    end

endmodule
